// File: hw/rtl/mec_pkg.sv
// mec_pkg: shared widths, register indexes, payload structs and saturation
// for the mandelbrot escape counter; used by every rtl file, depends on nothing
package mec_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int RI_W      = SQ_W + 1;
    localparam int LEN_W     = SQ_W + 1;
    localparam int SAT_W     = 48;

    localparam int COORD_W   = 12;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 17;
    localparam int CPROD_W   = COORD_W + STEP_W;
    localparam int MAX_DIM   = 4096;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(MAX_DIM - 1);

    localparam logic [LEN_W-1:0] ESCAPE_LIMIT = LEN_W'(64'd4 << FRAC_BITS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [WORD_W-1:0] RST_X_MIN    = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_Y_MIN    = -32'sd536870912;
    localparam logic [STEP_W-1:0]        RST_STEP_X   = 31'd1342177;
    localparam logic [STEP_W-1:0]        RST_STEP_Y   = 31'd1342177;
    localparam logic [ITER_W-1:0]        RST_MAX_ITER = 17'd100000;

    typedef struct packed {
        logic signed [WORD_W-1:0] x_min;
        logic signed [WORD_W-1:0] y_min;
        logic [STEP_W-1:0]        step_x;
        logic [STEP_W-1:0]        step_y;
    } plane_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]       column;
        logic [COORD_W-1:0]       row;
        logic signed [WORD_W-1:0] cr;
        logic signed [WORD_W-1:0] ci;
    } job_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [ITER_W-1:0]  iteration_count;
        logic               escaped;
    } result_t;

    // clamp a wide signed value into one word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        if (v[SAT_W-1:WORD_W-1] == '0 || v[SAT_W-1:WORD_W-1] == '1)
        begin
            return v[WORD_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: hw/rtl/mandelbrot_escape_counter.sv
// mandelbrot_escape_counter: top level, config registers and the
// front / queue / back chain; depends on mec_pkg, mec_front, mec_queue, mec_back
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: column, row
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pixel_column, pixel_row,
//                                              iteration_count; tuser: escaped
//  cfg       in   cfg_we                       cfg_index, cfg_wdata
//
//  back end: each iteration is a multiply step then an update step, and one pixel
//  is iterated at a time; the shared multiply/update loop sets the rate
//  front end maps a pixel into a register stage and fills a QUEUE_DEPTH deep queue
//  rst_n clears the queue, engine and output beat; registers take reset values
//  either side may stall; the queue and the output register keep the other moving
module mandelbrot_escape_counter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // column, row
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // pixel_column, pixel_row, iteration_count
    output logic [0:0]                    m_axis_tuser,  // escaped
    input  logic                          cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    mec_pkg::plane_cfg_t        plane_reg;
    logic [mec_pkg::ITER_W-1:0] max_iter_reg;

    logic             push;
    mec_pkg::job_t    push_data;
    logic             q_full;
    logic             pop;
    mec_pkg::job_t    pop_data;
    logic             q_empty;
    mec_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.x_min  <= mec_pkg::RST_X_MIN;
            plane_reg.y_min  <= mec_pkg::RST_Y_MIN;
            plane_reg.step_x <= mec_pkg::RST_STEP_X;
            plane_reg.step_y <= mec_pkg::RST_STEP_Y;
            max_iter_reg     <= mec_pkg::RST_MAX_ITER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mec_pkg::REG_X_MIN:    plane_reg.x_min  <= cfg_wdata;
                mec_pkg::REG_Y_MIN:    plane_reg.y_min  <= cfg_wdata;
                mec_pkg::REG_STEP_X:   plane_reg.step_x <= cfg_wdata[mec_pkg::STEP_W-1:0];
                mec_pkg::REG_STEP_Y:   plane_reg.step_y <= cfg_wdata[mec_pkg::STEP_W-1:0];
                mec_pkg::REG_MAX_ITER: max_iter_reg     <= cfg_wdata[mec_pkg::ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (plane_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .column    (s_axis_tdata[11:0]),
        .row       (s_axis_tdata[23:12]),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    mec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    mec_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (max_iter_reg),
        .job_valid      (!q_empty),
        .job            (pop_data),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .result         (result)
    );

    assign m_axis_tdata = {7'd0, result.iteration_count, result.pixel_row, result.pixel_column};
    assign m_axis_tuser = result.escaped;

endmodule

// File: hw/rtl/mec_front.sv
// mec_front: accepts pixel beats and maps them to the complex point c
// depends on mec_pkg; feeds mec_queue
module mec_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mec_pkg::plane_cfg_t         cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mec_pkg::COORD_W-1:0] column,
    input  logic [mec_pkg::COORD_W-1:0] row,
    input  logic                        q_full,
    output logic                        push,
    output mec_pkg::job_t               push_data
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [mec_pkg::COORD_W-1:0] s1_col_reg;
    logic [mec_pkg::COORD_W-1:0] s1_row_reg;
    logic [mec_pkg::CPROD_W-1:0] s1_px_reg;
    logic [mec_pkg::CPROD_W-1:0] s1_py_reg;
    logic [mec_pkg::COORD_W-1:0] col_w;
    logic [mec_pkg::COORD_W-1:0] row_w;
    logic                        in_accept;
    logic signed [mec_pkg::SAT_W-1:0] sum_x;
    logic signed [mec_pkg::SAT_W-1:0] sum_y;

    assign in_ready  = !s1_valid_reg || !q_full;
    assign in_accept = in_valid && in_ready;
    assign push      = s1_valid_reg && !q_full;
    assign col_w     = column & mec_pkg::COORD_MASK;
    assign row_w     = row & mec_pkg::COORD_MASK;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    assign sum_x = mec_pkg::SAT_W'(cfg.x_min) + $signed(mec_pkg::SAT_W'(s1_px_reg));
    assign sum_y = mec_pkg::SAT_W'(cfg.y_min) + $signed(mec_pkg::SAT_W'(s1_py_reg));

    assign push_data.column = s1_col_reg;
    assign push_data.row    = s1_row_reg;
    assign push_data.cr     = mec_pkg::sat_word(sum_x);
    assign push_data.ci     = mec_pkg::sat_word(sum_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg <= col_w;
            s1_row_reg <= row_w;
            s1_px_reg  <= mec_pkg::CPROD_W'(col_w) * mec_pkg::CPROD_W'(cfg.step_x);
            s1_py_reg  <= mec_pkg::CPROD_W'(row_w) * mec_pkg::CPROD_W'(cfg.step_y);
        end
    end

endmodule

// File: hw/rtl/mec_queue.sv
// mec_queue: small first-in first-out queue of mapped pixels
// depends on mec_pkg; sits between mec_front and mec_back
module mec_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mec_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output mec_pkg::job_t pop_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mec_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;

    assign full     = (fill_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> fill_reg == (PTR_W+1)'(DEPTH))
        else $error("queue fill changed while full and not drained");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> empty)
        else $error("queue left empty without a push");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> $stable(fill_reg))
        else $error("queue fill moved on a simultaneous push and pop");

endmodule

// File: hw/rtl/mec_back.sv
// mec_back: escape-time iteration engine with its result register
// depends on mec_pkg; takes jobs from mec_queue
module mec_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mec_pkg::ITER_W-1:0] max_iterations,
    input  logic                       job_valid,
    input  mec_pkg::job_t              job,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mec_pkg::result_t           result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    logic [mec_pkg::COORD_W-1:0]      col_reg;
    logic [mec_pkg::COORD_W-1:0]      row_reg;
    logic signed [mec_pkg::WORD_W-1:0] cr_reg;
    logic signed [mec_pkg::WORD_W-1:0] ci_reg;
    logic signed [mec_pkg::WORD_W-1:0] zr_reg;
    logic signed [mec_pkg::WORD_W-1:0] zi_reg;
    logic [mec_pkg::ITER_W-1:0]        count_reg;
    logic signed [mec_pkg::PROD_W-1:0] p_rr_reg;
    logic signed [mec_pkg::PROD_W-1:0] p_ii_reg;
    logic signed [mec_pkg::PROD_W-1:0] p_ri_reg;
    mec_pkg::result_t                  res_reg;

    logic signed [mec_pkg::SQ_W-1:0]   rr;
    logic signed [mec_pkg::SQ_W-1:0]   ii;
    logic signed [mec_pkg::RI_W-1:0]   ri2;
    logic [mec_pkg::LEN_W-1:0]         lensq;
    logic                              escape;
    logic                              stop;
    logic                              out_free;
    logic                              res_load;
    logic                              step;
    logic signed [mec_pkg::WORD_W-1:0] zr_new;
    logic signed [mec_pkg::WORD_W-1:0] zi_new;

    // squares are never negative, so the length needs no sign
    assign rr     = p_rr_reg[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
    assign ii     = p_ii_reg[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
    assign ri2    = p_ri_reg[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS-1];
    assign lensq  = mec_pkg::LEN_W'(unsigned'(rr)) + mec_pkg::LEN_W'(unsigned'(ii));
    assign escape = (lensq >= mec_pkg::ESCAPE_LIMIT);
    assign stop   = escape || (count_reg >= max_iterations);

    assign zr_new = mec_pkg::sat_word(mec_pkg::SAT_W'(rr) - mec_pkg::SAT_W'(ii)
                                      + mec_pkg::SAT_W'(cr_reg));
    assign zi_new = mec_pkg::sat_word(mec_pkg::SAT_W'(ri2) + mec_pkg::SAT_W'(ci_reg));

    assign out_free = !out_valid_reg || out_ready;
    assign res_load = (state_reg == ST_UPD) && stop && out_free;
    assign step     = (state_reg == ST_UPD) && !stop;
    assign pop      = (state_reg == ST_IDLE) && job_valid;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!stop)
                begin
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg   <= job.column;
            row_reg   <= job.row;
            cr_reg    <= job.cr;
            ci_reg    <= job.ci;
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            zr_reg    <= zr_new;
            zi_reg    <= zi_new;
            count_reg <= count_reg + 1'b1;
        end
        if (state_reg == ST_MUL)
        begin
            p_rr_reg <= mec_pkg::PROD_W'(zr_reg) * mec_pkg::PROD_W'(zr_reg);
            p_ii_reg <= mec_pkg::PROD_W'(zi_reg) * mec_pkg::PROD_W'(zi_reg);
            p_ri_reg <= mec_pkg::PROD_W'(zr_reg) * mec_pkg::PROD_W'(zi_reg);
        end
        if (res_load)
        begin
            res_reg.pixel_column    <= col_reg;
            res_reg.pixel_row       <= row_reg;
            res_reg.iteration_count <= count_reg;
            res_reg.escaped         <= escape;
        end
    end

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg && res_reg.iteration_count == $past(count_reg))
        else $error("result beat not presented after load");
    a_cap_hit: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && !escape |-> count_reg == max_iterations)
        else $error("non-escaped result below the iteration cap");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |-> count_reg <= max_iterations)
        else $error("iteration count ran past the cap");
    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_UPD)
        else $error("multiply cycle not followed by update");

endmodule
